// ===== hw/rtl/aeske_pkg.sv =====
// Shared constants and helpers for the AES key expansion block.
// Holds the forward S-box table, the first round constant and the GF(2^8) doubling.
// No dependencies.
`default_nettype none

package aeske_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W = 4;
	localparam logic [IDX_W-1:0] LAST_ROUND_128 = 4'd10;
	localparam logic [IDX_W-1:0] LAST_ROUND_256 = 4'd14;
	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [0:255][7:0] SBOX = {
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aeske_sub_word.sv =====
// Shared SubWord unit: four parallel forward S-box lookups on one 32-bit word.
// Depends on aeske_pkg for the S-box table.
`default_nettype none

module aeske_sub_word
	import aeske_pkg::*;
(
	input  wire logic [WORD_W-1:0] word_in,
	output logic      [WORD_W-1:0] word_out
);

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			word_out[8*b +: 8] = SBOX[word_in[8*b +: 8]];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/aes_key_expansion_128_256.sv =====
// AES-128/AES-256 encryption key schedule; uses aeske_pkg and the aeske_sub_word unit.
// Round key 0 is shown in the cycle after the key transfer.
// Throughput: one round key per cycle without stall; the single SubWord unit is
// used once per round key.
// A new key is taken in the cycle in which the final round key transfers.
// Reset clears the valid flag and the sequencer; the key window needs no reset.
`default_nettype none

module aes_key_expansion_128_256
	import aeske_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        key_valid,
	output logic             key_stall,
	input  wire logic        long_key,
	input  wire logic [63:0] key_part0,
	input  wire logic [63:0] key_part1,
	input  wire logic [63:0] key_part2,
	input  wire logic [63:0] key_part3,
	output logic             rk_valid,
	input  wire logic        rk_stall,
	output logic [3:0]       round_index,
	output logic [63:0]      round_key_low,
	output logic [63:0]      round_key_high,
	output logic             last_key
);

	logic [WORD_W-1:0] win_q [8];
	logic              valid_q;
	logic              long_q;
	logic              phase_q;
	logic [IDX_W-1:0]  rnd_q;
	logic [7:0]        rcon_q;

	logic              key_xfer;
	logic              rk_xfer;
	logic              use_rot;
	logic [WORD_W-1:0] prev_word;
	logic [WORD_W-1:0] sub_in;
	logic [WORD_W-1:0] sub_out;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] nw [4];

	assign rk_valid = valid_q;
	assign last_key = valid_q && (rnd_q == (long_q ? LAST_ROUND_256 : LAST_ROUND_128));
	assign rk_xfer = valid_q && !rk_stall;
	assign key_stall = valid_q && !(last_key && !rk_stall);
	assign key_xfer = key_valid && !key_stall;

	assign round_index = rnd_q;
	assign round_key_low = {win_q[1], win_q[0]};
	assign round_key_high = {win_q[3], win_q[2]};

	assign use_rot = !long_q || !phase_q;
	assign prev_word = long_q ? win_q[7] : win_q[3];
	assign sub_in = use_rot ? {prev_word[7:0], prev_word[31:8]} : prev_word;

	aeske_sub_word u_sub_word (
		.word_in  (sub_in),
		.word_out (sub_out)
	);

	assign mix = sub_out ^ (use_rot ? {24'h000000, rcon_q} : {WORD_W{1'b0}});

	always_comb begin
		nw[0] = win_q[0] ^ mix;
		nw[1] = win_q[1] ^ nw[0];
		nw[2] = win_q[2] ^ nw[1];
		nw[3] = win_q[3] ^ nw[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rnd_q <= '0;
			phase_q <= 1'b0;
			rcon_q <= RCON_FIRST;
			long_q <= 1'b0;
		end else if (key_xfer) begin
			valid_q <= 1'b1;
			rnd_q <= '0;
			phase_q <= 1'b0;
			rcon_q <= RCON_FIRST;
			long_q <= long_key;
		end else if (rk_xfer) begin
			if (last_key) begin
				valid_q <= 1'b0;
			end
			rnd_q <= rnd_q + 1'b1;
			phase_q <= !phase_q;
			if (use_rot) begin
				rcon_q <= xtime(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_xfer) begin
			win_q[0] <= key_part0[31:0];
			win_q[1] <= key_part0[63:32];
			win_q[2] <= key_part1[31:0];
			win_q[3] <= key_part1[63:32];
			win_q[4] <= key_part2[31:0];
			win_q[5] <= key_part2[63:32];
			win_q[6] <= key_part3[31:0];
			win_q[7] <= key_part3[63:32];
		end else if (rk_xfer) begin
			if (long_q) begin
				for (int i = 0; i < 4; i++) begin
					win_q[i] <= win_q[i+4];
					win_q[i+4] <= nw[i];
				end
			end else begin
				for (int i = 0; i < 4; i++) begin
					win_q[i] <= nw[i];
				end
			end
		end
	end

`ifndef SYNTHESIS
	// A key transfer always starts a schedule at round zero.
	a_start_round0: assert property (@(posedge clk) disable iff (!arst_n)
		key_xfer |=> rk_valid && round_index == '0)
		else $error("schedule did not start at round zero");

	// Round numbers advance by one on every transfer that is not the last.
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		rk_xfer && !last_key |=> rk_valid && round_index == $past(round_index) + 1'b1)
		else $error("round index did not advance by one");

	// The final round key matches the key length of the schedule.
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		last_key |-> (round_index == LAST_ROUND_128 && !long_q) ||
			(round_index == LAST_ROUND_256 && long_q))
		else $error("final round key at wrong round");

	// A new key is only taken when the previous schedule is done.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		key_xfer |-> !rk_valid || (last_key && !rk_stall))
		else $error("key taken while schedule still running");
`endif

endmodule

`default_nettype wire
